// ===== rtl/dcmpn_pkg.sv =====
// Shared widths, constants and control types of the mean and peak normalizer.
`timescale 1ns / 1ps
package dcmpn_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int SUM_W     = 18;
	localparam int NORM_W    = 16;
	localparam int FRAC_BITS = 14;
	localparam int ADDR_W    = 6;
	localparam int DIV_W     = SAMPLE_W + FRAC_BITS;
	localparam int DIV_RADIX = 2;
	localparam int DIV_CYCLES = DIV_W / DIV_RADIX;
	localparam int CNT_W     = $clog2(DIV_CYCLES);

	typedef struct packed {
		logic              load;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              div_start;
		logic              div_mean;
		logic              mean_capture;
		logic              out_load;
		logic              out_last;
		logic              clear_block;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/dcmpn_if.sv =====
// Valid/ready channel interfaces for sample pairs and normalized results.
`timescale 1ns / 1ps
interface dcmpn_in_if;
	logic                          valid;
	logic                          ready;
	logic [dcmpn_pkg::SAMPLE_W-1:0] sample_a;
	logic [dcmpn_pkg::SAMPLE_W-1:0] sample_b;

	modport source (output valid, output sample_a, output sample_b, input ready);
	modport sink (input valid, input sample_a, input sample_b, output ready);
endinterface

interface dcmpn_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [dcmpn_pkg::NORM_W-1:0] norm_a;
	logic signed [dcmpn_pkg::NORM_W-1:0] norm_b;
	logic                               last_of_block;

	modport source (output valid, output norm_a, output norm_b, output last_of_block,
		input ready);
	modport sink (input valid, input norm_a, input norm_b, input last_of_block,
		output ready);
endinterface

// ===== rtl/dcmpn_div.sv =====
// Unsigned restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps
module dcmpn_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dcmpn_pkg::DIV_W-1:0]    dividend,
	input  logic [dcmpn_pkg::SAMPLE_W-1:0] divisor,
	output logic                           busy,
	output logic                           done,
	output logic [dcmpn_pkg::DIV_W-1:0]    quotient
);
	logic [dcmpn_pkg::DIV_W-1:0]    work_q;
	logic [dcmpn_pkg::SAMPLE_W-1:0] rem_q;
	logic [dcmpn_pkg::SAMPLE_W-1:0] divisor_q;
	logic [dcmpn_pkg::CNT_W-1:0]    cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [dcmpn_pkg::DIV_W-1:0]    work_nxt;
	logic [dcmpn_pkg::SAMPLE_W-1:0] rem_nxt;

	always_comb begin
		logic [dcmpn_pkg::SAMPLE_W:0] trial;
		work_nxt = work_q;
		rem_nxt  = rem_q;
		for (int i = 0; i < dcmpn_pkg::DIV_RADIX; i++) begin
			trial    = {rem_nxt, work_nxt[dcmpn_pkg::DIV_W-1]};
			work_nxt = {work_nxt[dcmpn_pkg::DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor_q}) begin
				rem_nxt     = dcmpn_pkg::SAMPLE_W'(trial - {1'b0, divisor_q});
				work_nxt[0] = 1'b1;
			end else begin
				rem_nxt = trial[dcmpn_pkg::SAMPLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= dcmpn_pkg::CNT_W'(dcmpn_pkg::DIV_CYCLES - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= work_nxt;
			rem_q  <= rem_nxt;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = work_q;

endmodule

// ===== rtl/dcmpn_dp.sv =====
// Datapath: sample store, sums, peaks, mean, the two dividers and the result register.
`timescale 1ns / 1ps
module dcmpn_dp #(
	parameter int SAMPLES = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dcmpn_pkg::cmd_t                       cmd,
	output dcmpn_pkg::status_t                    sts,
	input  logic [dcmpn_pkg::SAMPLE_W-1:0]        sample_a,
	input  logic [dcmpn_pkg::SAMPLE_W-1:0]        sample_b,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [dcmpn_pkg::NORM_W-1:0]   norm_a,
	output logic signed [dcmpn_pkg::NORM_W-1:0]   norm_b,
	output logic                                  last_of_block
);
	localparam int AW = $clog2(SAMPLES);
	localparam int SW = dcmpn_pkg::SAMPLE_W;

	logic [2*SW-1:0]                store_q [SAMPLES];
	logic [2*SW-1:0]                rd_data_q;
	logic [dcmpn_pkg::SUM_W-1:0]    sum_a_q, sum_b_q;
	logic [SW-1:0]                  peak_a_q, peak_b_q;
	logic [SW-1:0]                  mean_a_q, mean_b_q;
	logic                           out_valid_q;
	logic signed [dcmpn_pkg::NORM_W-1:0] norm_a_q, norm_b_q;
	logic                           last_q;

	logic signed [SW:0]             diff_a, diff_b;
	logic [SW-1:0]                  mag_a, mag_b;
	logic [dcmpn_pkg::DIV_W-1:0]    dvd_a, dvd_b;
	logic [SW-1:0]                  dvs_a, dvs_b;
	logic [dcmpn_pkg::DIV_W-1:0]    quo_a, quo_b;
	logic                           busy_a, busy_b, done_a, done_b;
	logic [dcmpn_pkg::NORM_W-1:0]   q16_a, q16_b;

	// sample store, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			store_q[cmd.wr_addr[AW-1:0]] <= {sample_a, sample_b};
		end
		if (cmd.rd_en) begin
			rd_data_q <= store_q[cmd.rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			peak_a_q <= '0;
			peak_b_q <= '0;
		end else if (cmd.clear_block) begin
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			peak_a_q <= '0;
			peak_b_q <= '0;
		end else if (cmd.load) begin
			sum_a_q <= sum_a_q + dcmpn_pkg::SUM_W'(sample_a);
			sum_b_q <= sum_b_q + dcmpn_pkg::SUM_W'(sample_b);
			if (sample_a > peak_a_q) begin
				peak_a_q <= sample_a;
			end
			if (sample_b > peak_b_q) begin
				peak_b_q <= sample_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mean_capture) begin
			mean_a_q <= quo_a[SW-1:0];
			mean_b_q <= quo_b[SW-1:0];
		end
	end

	// signed distance from the mean and its magnitude
	assign diff_a = $signed({1'b0, rd_data_q[2*SW-1:SW]}) - $signed({1'b0, mean_a_q});
	assign diff_b = $signed({1'b0, rd_data_q[SW-1:0]}) - $signed({1'b0, mean_b_q});
	assign mag_a  = diff_a[SW] ? SW'(-diff_a) : diff_a[SW-1:0];
	assign mag_b  = diff_b[SW] ? SW'(-diff_b) : diff_b[SW-1:0];

	// the same dividers produce the block mean and each quotient
	assign dvd_a = cmd.div_mean ? dcmpn_pkg::DIV_W'(sum_a_q)
		: {mag_a, {dcmpn_pkg::FRAC_BITS{1'b0}}};
	assign dvd_b = cmd.div_mean ? dcmpn_pkg::DIV_W'(sum_b_q)
		: {mag_b, {dcmpn_pkg::FRAC_BITS{1'b0}}};
	assign dvs_a = cmd.div_mean ? SW'(SAMPLES) : peak_a_q;
	assign dvs_b = cmd.div_mean ? SW'(SAMPLES) : peak_b_q;

	dcmpn_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd_a),
		.divisor  (dvs_a),
		.busy     (busy_a),
		.done     (done_a),
		.quotient (quo_a)
	);

	dcmpn_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd_b),
		.divisor  (dvs_b),
		.busy     (busy_b),
		.done     (done_b),
		.quotient (quo_b)
	);

	assign q16_a = quo_a[dcmpn_pkg::NORM_W-1:0];
	assign q16_b = quo_b[dcmpn_pkg::NORM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// zero peak means an all-zero channel: its result is zero
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			norm_a_q <= (peak_a_q == '0) ? '0 : (diff_a[SW] ? -q16_a : q16_a);
			norm_b_q <= (peak_b_q == '0) ? '0 : (diff_b[SW] ? -q16_b : q16_b);
			last_q   <= cmd.out_last;
		end
	end

	assign sts.div_busy  = busy_a | busy_b;
	assign sts.div_done  = done_a & done_b;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign norm_a        = norm_a_q;
	assign norm_b        = norm_b_q;
	assign last_of_block = last_q;

endmodule

// ===== rtl/dcmpn_ctrl.sv =====
// Controller: block fill count, mean phase and per-result emit sequence.
`timescale 1ns / 1ps
module dcmpn_ctrl #(
	parameter int SAMPLES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dcmpn_pkg::status_t   sts,
	output dcmpn_pkg::cmd_t      cmd
);
	localparam int AW = $clog2(SAMPLES);

	typedef enum logic [2:0] {
		S_LOAD,
		S_MEAN,
		S_MEAN_WAIT,
		S_READ,
		S_DIV,
		S_DIV_WAIT,
		S_PUSH
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   fill_q;
	logic [AW-1:0]   idx_q;
	logic            fill_last, idx_last;

	assign fill_last = (fill_q == AW'(SAMPLES - 1));
	assign idx_last  = (idx_q == AW'(SAMPLES - 1));

	always_comb begin
		cmd              = '0;
		cmd.load         = (state_q == S_LOAD) && in_valid;
		cmd.wr_addr      = dcmpn_pkg::ADDR_W'(fill_q);
		cmd.rd_en        = (state_q == S_READ);
		cmd.rd_addr      = dcmpn_pkg::ADDR_W'(idx_q);
		cmd.div_start    = (state_q == S_MEAN) || (state_q == S_DIV);
		cmd.div_mean     = (state_q == S_MEAN);
		cmd.mean_capture = (state_q == S_MEAN_WAIT) && sts.div_done;
		cmd.out_load     = (state_q == S_PUSH) && sts.out_free;
		cmd.out_last     = idx_last;
		cmd.clear_block  = cmd.out_load && idx_last;
	end

	assign in_ready = (state_q == S_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (fill_last) begin
							fill_q  <= '0;
							state_q <= S_MEAN;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				S_MEAN: begin
					state_q <= S_MEAN_WAIT;
				end
				S_MEAN_WAIT: begin
					if (sts.div_done) begin
						idx_q   <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (sts.div_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (sts.out_free) begin
						if (idx_last) begin
							state_q <= S_LOAD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// a result is only loaded into a free output register
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while output register is occupied");

	// no sample pair is taken while the dividers are working
	a_load_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !sts.div_busy)
		else $error("sample accepted during a division");

	// a division never completes in the cycle right after it starts
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider done too early");

	// the block state clears only with the final result
	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_block |=> (state_q == S_LOAD) && (fill_q == '0))
		else $error("block cleared without returning to load");

endmodule

// ===== rtl/dual_channel_mean_peak_normalizer.sv =====
// Top level of the dual-channel mean removal and peak normalizer.
`timescale 1ns / 1ps
// Collects SAMPLES pairs of unsigned 12-bit samples, one pair per input beat,
// while keeping a running sum and peak per channel. When the block is full the
// input stalls while the block is emitted: the two block means come first from
// the channel dividers, then each stored pair yields one result beat of
// (sample - mean) * 16384 / peak, truncated toward zero, with a zero result for
// a channel whose peak is zero. Each result passes through a store read, a
// divider start, a radix-4 divide until its done, and an output load before
// the next pair is read, so the serial dividers set the emit time; a stalled
// output adds its wait to each result. last_of_block marks the final result;
// after it the block state clears and loading resumes, even while that final
// beat still waits.
module dual_channel_mean_peak_normalizer #(
	parameter int SAMPLES = 64
) (
	input logic          clk,
	input logic          arst_n,
	dcmpn_in_if.sink     samples,
	dcmpn_out_if.source  results
);
	dcmpn_pkg::cmd_t    cmd;
	dcmpn_pkg::status_t sts;

	// sequencing: fill, mean, then read/divide/push per stored pair
	dcmpn_ctrl #(
		.SAMPLES (SAMPLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, accumulation, division and the result register
	dcmpn_dp #(
		.SAMPLES (SAMPLES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.sample_a      (samples.sample_a),
		.sample_b      (samples.sample_b),
		.out_valid     (results.valid),
		.out_ready     (results.ready),
		.norm_a        (results.norm_a),
		.norm_b        (results.norm_b),
		.last_of_block (results.last_of_block)
	);

endmodule
